[rtl/ray_segment_intersection_defines.svh]
// Assertion macros for the ray/segment intersection block.
// Used by the top level only; no other dependencies.
`ifndef RAY_SEGMENT_INTERSECTION_DEFINES_SVH
`define RAY_SEGMENT_INTERSECTION_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define RSI_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequence is checked on the following edge.
`define RSI_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/rsi_pkg.sv]
// Shared constants for the ray/segment intersection block.
// No dependencies.
`default_nettype none
package rsi_pkg;
   localparam int COORD_BITS_DEFAULT = 16;
   localparam int THRESH_BITS        = 21;
   localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(1);
endpackage
`default_nettype wire

[rtl/ray_segment_intersection.sv]
// Ray / wall-segment intersection, fully pipelined, one transaction per cycle.
// Stages: differences, products, determinants, hit decision, numerators, then a
// bit-per-stage divider for each hit coordinate, and the output register.
// Throughput: one transaction per cycle; a stalled rsp holds the whole pipe.
// Reset (synchronous, active high) empties the pipeline and sets the
// parallel threshold to 1.
`default_nettype none
module ray_segment_intersection
   import rsi_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // ray_origin_x, ray_origin_y, ray_through_x, ray_through_y,
   // seg_start_x, seg_start_y, seg_end_x, seg_end_y (lowest first)
   input  wire logic [8*COORD_BITS-1:0] req_tdata,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // hit, hit_x, hit_y (lowest first), zero filled to whole bytes
   output logic [((2*COORD_BITS+1+7)/8)*8-1:0] rsp_tdata,
   input  wire logic csr_we,
   input  wire logic [THRESH_BITS-1:0] csr_wdata
);
`include "ray_segment_intersection_defines.svh"

   localparam int CB  = COORD_BITS;
   localparam int DB  = CB + 1;          // coordinate difference
   localparam int PB  = 2 * DB;          // product of differences
   localparam int TB  = PB + 1;          // determinant, signed
   localparam int MB  = TB - 1;          // determinant magnitude
   localparam int NB  = MB + DB + 1;     // 2*|detS|*|diff| + |detA|
   localparam int QB  = DB;              // quotient fits difference
   localparam int OB  = ((2*CB+1+7)/8)*8;
   localparam int SB  = 1 + 2*CB;        // side: hit + two starts

   logic [THRESH_BITS-1:0] thresh_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_we) begin
         thresh_ff <= csr_wdata;
      end
   end

   // the whole pipe advances when the output stage is free or being drained
   logic advance;
   logic out_vld_ff;
   assign advance    = !out_vld_ff || rsp_tready;
   assign req_tready = advance;

   // ---- stage 1: differences
   logic s1_vld_ff;
   logic signed [DB-1:0] dx21_ff, dy21_ff, dx43_ff, dy43_ff, dx13_ff, dy13_ff;
   logic signed [CB-1:0] x3_s1_ff, y3_s1_ff;
   logic signed [CB-1:0] x1, y1, x2, y2, x3, y3, x4, y4;
   assign x1 = req_tdata[0*CB +: CB];
   assign y1 = req_tdata[1*CB +: CB];
   assign x2 = req_tdata[2*CB +: CB];
   assign y2 = req_tdata[3*CB +: CB];
   assign x3 = req_tdata[4*CB +: CB];
   assign y3 = req_tdata[5*CB +: CB];
   assign x4 = req_tdata[6*CB +: CB];
   assign y4 = req_tdata[7*CB +: CB];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (advance) begin
         s1_vld_ff <= req_tvalid;
      end
      if (advance) begin
         dx21_ff  <= DB'(x2) - DB'(x1);
         dy21_ff  <= DB'(y2) - DB'(y1);
         dx43_ff  <= DB'(x4) - DB'(x3);
         dy43_ff  <= DB'(y4) - DB'(y3);
         dx13_ff  <= DB'(x1) - DB'(x3);
         dy13_ff  <= DB'(y1) - DB'(y3);
         x3_s1_ff <= x3;
         y3_s1_ff <= y3;
      end
   end

   // ---- stage 2: six products
   // detA = dx21*dy43 - dy21*dx43
   // detT = dx13*(-dy43) - dy13*(-dx43) = dy13*dx43 - dx13*dy43
   // detS = dx21*dy13 - dy21*dx13
   logic s2_vld_ff;
   logic signed [PB-1:0] pa0_ff, pa1_ff, pt0_ff, pt1_ff, ps0_ff, ps1_ff;
   logic signed [DB-1:0] dx43_s2_ff, dy43_s2_ff;
   logic signed [CB-1:0] x3_s2_ff, y3_s2_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (advance) begin
         s2_vld_ff <= s1_vld_ff;
      end
      if (advance) begin
         pa0_ff     <= PB'(dx21_ff) * PB'(dy43_ff);
         pa1_ff     <= PB'(dy21_ff) * PB'(dx43_ff);
         pt0_ff     <= PB'(dy13_ff) * PB'(dx43_ff);
         pt1_ff     <= PB'(dx13_ff) * PB'(dy43_ff);
         ps0_ff     <= PB'(dx21_ff) * PB'(dy13_ff);
         ps1_ff     <= PB'(dy21_ff) * PB'(dx13_ff);
         dx43_s2_ff <= dx43_ff;
         dy43_s2_ff <= dy43_ff;
         x3_s2_ff   <= x3_s1_ff;
         y3_s2_ff   <= y3_s1_ff;
      end
   end

   // ---- stage 3: determinants
   logic s3_vld_ff;
   logic signed [TB-1:0] deta_ff, dett_ff, dets_ff;
   logic signed [DB-1:0] dx43_s3_ff, dy43_s3_ff;
   logic signed [CB-1:0] x3_s3_ff, y3_s3_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_vld_ff <= 1'b0;
      end else if (advance) begin
         s3_vld_ff <= s2_vld_ff;
      end
      if (advance) begin
         deta_ff    <= TB'(pa0_ff) - TB'(pa1_ff);
         dett_ff    <= TB'(pt0_ff) - TB'(pt1_ff);
         dets_ff    <= TB'(ps0_ff) - TB'(ps1_ff);
         dx43_s3_ff <= dx43_s2_ff;
         dy43_s3_ff <= dy43_s2_ff;
         x3_s3_ff   <= x3_s2_ff;
         y3_s3_ff   <= y3_s2_ff;
      end
   end

   // ---- stage 4: magnitudes and the hit decision
   logic [MB-1:0] amag, smag;
   logic          hit_in;
   assign amag = MB'(deta_ff[TB-1] ? -deta_ff : deta_ff);
   assign smag = MB'(dets_ff[TB-1] ? -dets_ff : dets_ff);
   always_comb begin
      hit_in = 1'b1;
      if (deta_ff == '0) hit_in = 1'b0;
      if (amag < MB'(thresh_ff)) hit_in = 1'b0;
      if (dett_ff != '0 && dett_ff[TB-1] != deta_ff[TB-1]) hit_in = 1'b0;
      if (dets_ff != '0 && dets_ff[TB-1] != deta_ff[TB-1]) hit_in = 1'b0;
      if (smag > amag) hit_in = 1'b0;
   end

   logic s4_vld_ff, hit_s4_ff;
   logic [MB-1:0] amag_ff, smag_ff;
   logic signed [DB-1:0] dx43_s4_ff, dy43_s4_ff;
   logic signed [CB-1:0] x3_s4_ff, y3_s4_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_vld_ff <= 1'b0;
      end else if (advance) begin
         s4_vld_ff <= s3_vld_ff;
      end
      if (advance) begin
         hit_s4_ff  <= hit_in;
         amag_ff    <= amag;
         smag_ff    <= smag;
         dx43_s4_ff <= dx43_s3_ff;
         dy43_s4_ff <= dy43_s3_ff;
         x3_s4_ff   <= x3_s3_ff;
         y3_s4_ff   <= y3_s3_ff;
      end
   end

   // ---- stage 5: numerators for rounding division
   logic [DB-1:0] mdx, mdy;
   assign mdx = DB'(dx43_s4_ff[DB-1] ? -dx43_s4_ff : dx43_s4_ff);
   assign mdy = DB'(dy43_s4_ff[DB-1] ? -dy43_s4_ff : dy43_s4_ff);

   logic s5_vld_ff;
   logic [NB-1:0] numx_ff, numy_ff;
   logic [MB:0]   den_ff;
   logic [SB+1:0] side5_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s5_vld_ff <= 1'b0;
      end else if (advance) begin
         s5_vld_ff <= s4_vld_ff;
      end
      if (advance) begin
         numx_ff  <= ((NB'(smag_ff) * NB'(mdx)) << 1) + NB'(amag_ff);
         numy_ff  <= ((NB'(smag_ff) * NB'(mdy)) << 1) + NB'(amag_ff);
         den_ff   <= {amag_ff, 1'b0};
         side5_ff <= {dy43_s4_ff[DB-1], dx43_s4_ff[DB-1], y3_s4_ff, x3_s4_ff, hit_s4_ff};
      end
   end

   // ---- divider pipelines, one per axis
   logic          qx_vld, qy_vld;
   logic [QB-1:0] qx, qy;
   logic [SB+1:0] side_q, side_unused;

   rsi_divider #(
      .NUM_BITS (NB), .DEN_BITS (MB+1), .Q_BITS (QB), .SIDE_BITS (SB+2)
   ) u_div_x (
      .clock, .reset, .advance,
      .in_valid (s5_vld_ff), .in_num (numx_ff), .in_den (den_ff),
      .in_side (side5_ff),
      .out_valid (qx_vld), .out_quot (qx), .out_side (side_q)
   );

   rsi_divider #(
      .NUM_BITS (NB), .DEN_BITS (MB+1), .Q_BITS (QB), .SIDE_BITS (SB+2)
   ) u_div_y (
      .clock, .reset, .advance,
      .in_valid (s5_vld_ff), .in_num (numy_ff), .in_den (den_ff),
      .in_side (side5_ff),
      .out_valid (qy_vld), .out_quot (qy), .out_side (side_unused)
   );

   // ---- output stage: apply the offset, zero on a miss
   logic          hit_q;
   logic [CB-1:0] x3_q, y3_q, hx, hy;
   assign hit_q = side_q[0];
   assign x3_q  = side_q[1 +: CB];
   assign y3_q  = side_q[1+CB +: CB];
   assign hx = side_q[SB]   ? x3_q - CB'(qx) : x3_q + CB'(qx);
   assign hy = side_q[SB+1] ? y3_q - CB'(qy) : y3_q + CB'(qy);

   logic [OB-1:0] out_data_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (advance) begin
         out_vld_ff <= qx_vld;
      end
      if (advance) begin
         out_data_ff <= OB'({(hit_q ? hy : CB'(0)), (hit_q ? hx : CB'(0)), hit_q});
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;

   // ---- checks
   `RSI_ASSERT_IMPL(a_div_lockstep, clock, reset, 1'b1, qx_vld == qy_vld,
      "divider lanes out of step")
   `RSI_ASSERT_IMPL(a_side_match, clock, reset, qx_vld, side_q == side_unused,
      "divider side payloads differ")
   `RSI_ASSERT_NEXT(a_hold_stall, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "result changed while stalled")
   `RSI_ASSERT_IMPL(a_miss_zero, clock, reset, rsp_tvalid && !rsp_tdata[0],
      rsp_tdata == '0, "miss carries nonzero point")
endmodule
`default_nettype wire

[rtl/rsi_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, stall by enable.
// Uses rsi_pkg; carries a side payload alongside the quotient.
`default_nettype none
module rsi_divider
   import rsi_pkg::*;
#(
   parameter int NUM_BITS = 40,
   parameter int DEN_BITS = 36,
   parameter int Q_BITS   = 17,
   parameter int SIDE_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic                 in_valid,
   input  wire logic [NUM_BITS-1:0]  in_num,
   input  wire logic [DEN_BITS-1:0]  in_den,
   input  wire logic [SIDE_BITS-1:0] in_side,
   output logic                      out_valid,
   output logic [Q_BITS-1:0]         out_quot,
   output logic [SIDE_BITS-1:0]      out_side
);
   // remainder width: den plus one guard bit
   localparam int RB = DEN_BITS + 1;

   logic                 vld_ff  [1:Q_BITS];
   logic [RB-1:0]        rem_ff  [1:Q_BITS-1];
   logic [NUM_BITS-1:0]  num_ff  [1:Q_BITS-1];
   logic [DEN_BITS-1:0]  den_ff  [1:Q_BITS-1];
   logic [Q_BITS-1:0]    quo_ff  [1:Q_BITS];
   logic [SIDE_BITS-1:0] side_ff [1:Q_BITS];

   // Quotient bit i of the result is formed in stage Q_BITS-i; the
   // quotient is known to fit Q_BITS, so higher numerator bits only feed
   // the initial remainder.
   for (genvar g = 0; g < Q_BITS; g++) begin : g_stage
      localparam int BIT = Q_BITS - 1 - g;
      logic                 vld_cur;
      logic [RB-1:0]        rem_cur;
      logic [NUM_BITS-1:0]  num_cur;
      logic [DEN_BITS-1:0]  den_cur;
      logic [Q_BITS-1:0]    quo_cur;
      logic [SIDE_BITS-1:0] side_cur;
      logic [RB:0]          trial;
      logic [RB-1:0]        rem_in;
      logic                 qbit;

      if (g == 0) begin : g_src
         assign vld_cur  = in_valid;
         assign rem_cur  = RB'(in_num >> Q_BITS);
         assign num_cur  = in_num;
         assign den_cur  = in_den;
         assign quo_cur  = '0;
         assign side_cur = in_side;
      end else begin : g_src
         assign vld_cur  = vld_ff[g];
         assign rem_cur  = rem_ff[g];
         assign num_cur  = num_ff[g];
         assign den_cur  = den_ff[g];
         assign quo_cur  = quo_ff[g];
         assign side_cur = side_ff[g];
      end

      always_comb begin
         trial  = {rem_cur, num_cur[BIT]};
         qbit   = (trial >= {2'b00, den_cur});
         rem_in = qbit ? RB'(trial - {2'b00, den_cur}) : RB'(trial);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[g+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[g+1] <= vld_cur;
         end
         if (advance) begin
            quo_ff[g+1]  <= quo_cur | (Q_BITS'(qbit) << BIT);
            side_ff[g+1] <= side_cur;
         end
      end

      // the last stage needs no remainder, numerator or divisor
      if (g < Q_BITS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[g+1] <= rem_in;
               num_ff[g+1] <= num_cur;
               den_ff[g+1] <= den_cur;
            end
         end
      end
   end

   assign out_valid = vld_ff[Q_BITS];
   assign out_quot  = quo_ff[Q_BITS];
   assign out_side  = side_ff[Q_BITS];
endmodule
`default_nettype wire
